@@ rtl/xor_frame_receiver_assert.svh @@
// Assertion macros used by the checker of the frame receiver.
`ifndef XOR_FRAME_RECEIVER_ASSERT_SVH
`define XOR_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/xfr_pkg.sv @@
package xfr_pkg;

	// Frame layout and checksum constants.
	localparam int BYTE_W         = 8;
	localparam int HDR_BYTES      = 8;
	localparam int HDR_IDX_W      = $clog2(HDR_BYTES);
	localparam logic [15:0] MIN_LEN = 16'd2;
	localparam logic [7:0] CKSUM_ANY = 8'hFF;

	// Configuration port.
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_FIRST  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_SECOND = 8'd1;

	// Result beat packing: field positions within m_tdata.
	localparam int TDATA_FIELDS_W = 67;
	localparam int TDATA_W        = 72;
	localparam int TDATA_PAD_W    = TDATA_W - TDATA_FIELDS_W;
	localparam int TUSER_W        = 2;
	localparam int BODY_LEN_LO    = 32;
	localparam int BODY_LEN_HI    = 47;
	localparam int ERR_LO         = 65;
	localparam int ERR_HI         = 66;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_START  = 2'd1,
		ERR_LENGTH = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_CHECK  = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  command_code;
		logic [7:0]  source_code;
		logic [15:0] device_number;
		logic [15:0] body_length;
		logic [7:0]  data_byte;
		logic [7:0]  received_checksum;
		logic        checksum_good;
		err_t        error_code;
		logic        frame_last;
	} result_t;

endpackage

@@ rtl/xfr_in_stage.sv @@
module xfr_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [xfr_pkg::BYTE_W-1:0] s_tdata,
	input  logic                       out_free,
	output logic                       step,
	output logic [xfr_pkg::BYTE_W-1:0] byte_s1
);

	logic valid_s1;

	// The held byte moves on whenever the result register has room.
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input byte register.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

@@ rtl/xfr_frame_fsm.sv @@
module xfr_frame_fsm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [xfr_pkg::BYTE_W-1:0] rx_byte,
	input  logic [7:0]                 start_first,
	input  logic [7:0]                 start_second,
	output logic                       res_valid,
	output xfr_pkg::result_t           res
);

	xfr_pkg::phase_t                       phase_q, phase_n;
	logic [xfr_pkg::HDR_IDX_W-1:0]         hdr_idx_q, hdr_idx_n;
	logic [xfr_pkg::HDR_BYTES-1:0][7:0]    hdr_q, hdr_n;
	logic [15:0]                           body_rem_q, body_rem_n;
	logic [7:0]                            xor_q, xor_n;
	logic [15:0]                           len_field;
	logic [15:0]                           dev_field;
	logic [15:0]                           body_cnt;

	// On the last header byte, the length comes from the store and the
	// device number's high byte is the byte arriving now.
	assign len_field = {hdr_q[5], hdr_q[4]};
	assign dev_field = {rx_byte, hdr_q[6]};
	assign body_cnt  = len_field - xfr_pkg::MIN_LEN;

	// Next state and result for the byte now in the input register.
	always_comb begin
		phase_n    = phase_q;
		hdr_idx_n  = hdr_idx_q;
		hdr_n      = hdr_q;
		body_rem_n = body_rem_q;
		xor_n      = xor_q;
		res_valid  = 1'b0;
		res        = '0;
		unique case (phase_q)
			xfr_pkg::PH_BODY: begin
				xor_n      = xor_q ^ rx_byte;
				body_rem_n = body_rem_q - 16'd1;
				if (body_rem_n == 16'd0) begin
					phase_n = xfr_pkg::PH_CHECK;
				end
				res_valid     = 1'b1;
				res.kind      = xfr_pkg::KIND_BODY;
				res.data_byte = rx_byte;
			end
			xfr_pkg::PH_CHECK: begin
				res_valid             = 1'b1;
				res.kind              = xfr_pkg::KIND_END;
				res.received_checksum = rx_byte;
				res.checksum_good     = (rx_byte == xor_q) ||
				                        (rx_byte == xfr_pkg::CKSUM_ANY);
				res.frame_last        = 1'b1;
				phase_n               = xfr_pkg::PH_HEADER;
				hdr_idx_n             = '0;
			end
			default: begin
				// Header collection; the unused phase code lands here too.
				phase_n          = xfr_pkg::PH_HEADER;
				hdr_n[hdr_idx_q] = rx_byte;
				hdr_idx_n        = hdr_idx_q + 1'b1;
				if (hdr_idx_q == xfr_pkg::HDR_IDX_W'(xfr_pkg::HDR_BYTES - 1)) begin
					res_valid = 1'b1;
					if (hdr_q[0] != start_first || hdr_q[1] != start_second) begin
						res.kind       = xfr_pkg::KIND_ERROR;
						res.error_code = xfr_pkg::ERR_START;
						res.frame_last = 1'b1;
					end else if (len_field < xfr_pkg::MIN_LEN) begin
						res.kind       = xfr_pkg::KIND_ERROR;
						res.error_code = xfr_pkg::ERR_LENGTH;
						res.frame_last = 1'b1;
					end else begin
						body_rem_n        = body_cnt;
						xor_n             = hdr_q[6] ^ rx_byte;
						phase_n           = (body_cnt != 16'd0) ? xfr_pkg::PH_BODY
						                                        : xfr_pkg::PH_CHECK;
						res.kind          = xfr_pkg::KIND_HEADER;
						res.command_code  = hdr_q[2];
						res.source_code   = hdr_q[3];
						res.device_number = dev_field;
						res.body_length   = body_cnt;
					end
				end
			end
		endcase
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= xfr_pkg::PH_HEADER;
			hdr_idx_q  <= '0;
			body_rem_q <= '0;
			xor_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			hdr_idx_q  <= hdr_idx_n;
			body_rem_q <= body_rem_n;
			xor_q      <= xor_n;
		end
	end

	// Header byte store; every byte is written before it is read.
	always_ff @(posedge clk) begin
		if (step) begin
			hdr_q <= hdr_n;
		end
	end

endmodule

@@ rtl/xfr_out_stage.sv @@
module xfr_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             res_valid,
	input  xfr_pkg::result_t res,
	input  logic             m_tready,
	output logic             out_free,
	output logic             valid_s2,
	output xfr_pkg::result_t res_s2
);

	// The register can take a new result once the current beat is gone.
	assign out_free = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= res_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

@@ rtl/xor_frame_receiver.sv @@
// Byte-serial receiver for framed messages with an XOR checksum.
// Slave stream (s_tvalid/s_tready/s_tdata) takes one received byte per beat.
// Master stream (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast) gives at most one
// result beat per input byte: a header, one beat per body byte, a frame end
// carrying the checksum verdict, or an error (bad start bytes or a length
// below two), after which the next header is hunted from scratch.
// The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the two
// expected start bytes; index 0 is the first, index 1 the second, other
// indexes are ignored. Write it only while no frame is in flight.
// Each accepted byte passes the input register, then the frame state update,
// then the result register that drives m_tvalid. Throughput: one byte per
// cycle while result beats are taken, set by the frame state update between
// the two registers.
// Reset clears both registers' valid flags, the frame state and the start
// bytes to zero. When m_tready is low the result beat holds, one more byte
// may be taken into the input register, and then s_tready drops until the
// result beat is taken.
module xor_frame_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: rx_byte[7:0]
	input  logic [7:0]                      s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: command_code[7:0], source_code[15:8], device_number[31:16],
	// body_length[47:32], data_byte[55:48], received_checksum[63:56],
	// checksum_good[64], error_code[66:65], zero[71:67]
	output logic [xfr_pkg::TDATA_W-1:0]     m_tdata,
	// m_tuser: result_kind[1:0]
	output logic [xfr_pkg::TUSER_W-1:0]     m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [xfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);

	logic [7:0]       start_first_val_q;
	logic [7:0]       start_second_val_q;
	logic             out_free;
	logic             step;
	logic [7:0]       byte_s1;
	logic             res_valid;
	xfr_pkg::result_t res;
	xfr_pkg::result_t res_s2;

	assign cfg_ready = 1'b1;

	// Start byte registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_val_q  <= '0;
			start_second_val_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				xfr_pkg::CFG_START_FIRST: begin
					start_first_val_q <= cfg_data;
				end
				xfr_pkg::CFG_START_SECOND: begin
					start_second_val_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	xfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.out_free (out_free),
		.step     (step),
		.byte_s1  (byte_s1)
	);

	xfr_frame_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte      (byte_s1),
		.start_first  (start_first_val_q),
		.start_second (start_second_val_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	xfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.res_valid (res_valid),
		.res       (res),
		.m_tready  (m_tready),
		.out_free  (out_free),
		.valid_s2  (m_tvalid),
		.res_s2    (res_s2)
	);

	// Pack the result beat, first field in the lowest bits.
	assign m_tdata = {{xfr_pkg::TDATA_PAD_W{1'b0}}, res_s2.error_code, res_s2.checksum_good,
	                  res_s2.received_checksum, res_s2.data_byte, res_s2.body_length,
	                  res_s2.device_number, res_s2.source_code, res_s2.command_code};
	assign m_tuser = res_s2.kind;
	assign m_tlast = res_s2.frame_last;

endmodule

@@ rtl/xfr_checker.sv @@
`include "xor_frame_receiver_assert.svh"

module xfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [xfr_pkg::TDATA_W-1:0] m_tdata,
	input logic [xfr_pkg::TUSER_W-1:0] m_tuser,
	input logic                        m_tlast
);

	// A stalled result beat stays in place.
	`XFR_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

	// Only frame ends and errors close a frame.
	`XFR_ASSERT_NOW(a_last_kind, m_tvalid, m_tlast == (m_tuser == xfr_pkg::KIND_END || m_tuser == xfr_pkg::KIND_ERROR), "tlast does not match result kind")

	// An error beat carries a nonzero error code, any other beat none.
	`XFR_ASSERT_NOW(a_err_code, m_tvalid, (m_tdata[xfr_pkg::ERR_HI:xfr_pkg::ERR_LO] != 2'd0) == (m_tuser == xfr_pkg::KIND_ERROR), "error code does not match result kind")

	// Body length only shows up on a header beat.
	`XFR_ASSERT_NOW(a_len_kind, m_tvalid && m_tuser != xfr_pkg::KIND_HEADER, m_tdata[xfr_pkg::BODY_LEN_HI:xfr_pkg::BODY_LEN_LO] == 16'd0, "body length on a non-header beat")

endmodule

bind xor_frame_receiver xfr_checker u_xfr_checker (.*);

@@ bench/xor_frame_receiver_test.sv @@
`timescale 1ns / 100ps

module xor_frame_receiver_test;

	// Stimulus actions the source side works through in order.
	typedef enum logic [1:0] {
		ACT_BYTE,
		ACT_WRITE,
		ACT_DRAIN,
		ACT_HOLD
	} action_kind_t;

	typedef struct {
		action_kind_t kind;
		logic [7:0]   index;
		logic [7:0]   value;
	} action_t;

	// Ways to close a frame.
	localparam int SUM_XOR   = 0;
	localparam int SUM_ANY   = 1;
	localparam int SUM_NOISY = 2;

	localparam logic [xfr_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = 8'd2;
	localparam logic [xfr_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

	localparam int SETTLE_CYCLES  = 4;
	localparam int IDLE_LIMIT     = 1000;
	localparam int BYTE_TARGET    = 400;
	localparam int PHASE_BYTES    = 80;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [xfr_pkg::TDATA_W-1:0]     m_tdata;
	logic [xfr_pkg::TUSER_W-1:0]     m_tuser;
	logic                            m_tlast;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [xfr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]                      cfg_data  = '0;

	xor_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	action_t pending [$];
	xfr_pkg::result_t frame_results [$];

	// Start bytes as the stimulus generator assumes them.
	logic [7:0] gen_first  = '0;
	logic [7:0] gen_second = '0;
	int         queued_bytes = 0;

	// Decoder state, mirroring the block.
	logic [7:0]      start_first  = '0;
	logic [7:0]      start_second = '0;
	xfr_pkg::phase_t rx_phase     = xfr_pkg::PH_HEADER;
	logic [2:0]      hdr_count    = '0;
	logic [7:0]      hdr_bytes [xfr_pkg::HDR_BYTES];
	logic [15:0]     body_left    = '0;
	logic [7:0]      run_xor      = '0;

	// Handshake flags seen at the last rising edge.
	logic byte_taken   = 1'b0;
	logic write_taken  = 1'b0;
	logic result_taken = 1'b0;

	// Source and sink pacing.
	bit          offering      = 1'b0;
	bit          offer_write   = 1'b0;
	bit          source_tight  = 1'b0;
	bit          sink_tight    = 1'b0;
	int unsigned source_gap    = 0;
	int unsigned sink_gap      = 0;
	int unsigned sink_hold     = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served  = 0;

	// Run statistics.
	int mismatch_count = 0;
	int bytes_taken    = 0;
	int writes_taken   = 0;
	int beats_checked  = 0;
	int frames_closed  = 0;
	int sums_good      = 0;
	int header_errors  = 0;
	int idle_cycles    = 0;

	xfr_pkg::result_t seen_beat;
	xfr_pkg::result_t want_beat;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Appends one action to the end of the stimulus queue.
	task automatic enqueue(input action_kind_t kind, input logic [7:0] index,
			input logic [7:0] value);
		action_t act;
		act.kind = kind;
		act.index = index;
		act.value = value;
		pending.insert(pending.size(), act);
	endtask

	task automatic queue_byte(input logic [7:0] value);
		enqueue(ACT_BYTE, 8'd0, value);
		queued_bytes++;
	endtask

	// Register writes wait until the block has gone quiet.
	task automatic queue_write(input logic [7:0] index, input logic [7:0] value);
		enqueue(ACT_DRAIN, 8'd0, 8'd0);
		enqueue(ACT_WRITE, index, value);
		if (index == xfr_pkg::CFG_START_FIRST)
			gen_first = value;
		else if (index == xfr_pkg::CFG_START_SECOND)
			gen_second = value;
	endtask

	task automatic queue_hold();
		enqueue(ACT_HOLD, 8'd0, 8'd0);
	endtask

	// A header, and where the header is good, a random body and a checksum.
	task automatic queue_frame(input logic [7:0] sb_first, input logic [7:0] sb_second,
			input logic [7:0] cmd, input logic [7:0] src, input logic [15:0] len,
			input logic [15:0] dev, input int sum_mode);
		logic [7:0] sum;
		logic [7:0] body_byte;
		queue_byte(sb_first);
		queue_byte(sb_second);
		queue_byte(cmd);
		queue_byte(src);
		queue_byte(len[7:0]);
		queue_byte(len[15:8]);
		queue_byte(dev[7:0]);
		queue_byte(dev[15:8]);
		if (sb_first == gen_first && sb_second == gen_second && len >= xfr_pkg::MIN_LEN) begin
			sum = dev[7:0] ^ dev[15:8];
			repeat (len - xfr_pkg::MIN_LEN) begin
				body_byte = 8'($urandom);
				sum ^= body_byte;
				queue_byte(body_byte);
			end
			case (sum_mode)
				SUM_XOR: queue_byte(sum);
				SUM_ANY: queue_byte(xfr_pkg::CKSUM_ANY);
				default: queue_byte(sum ^ (8'd1 << $urandom_range(0, 7)));
			endcase
		end
	endtask

	task automatic queue_good_frame(input logic [15:0] len);
		queue_frame(gen_first, gen_second, 8'($urandom), 8'($urandom), len,
			16'($urandom), $urandom_range(SUM_XOR, SUM_NOISY));
	endtask

	// Works out the result beat, if any, that one received byte causes.
	task automatic decode_byte(input logic [7:0] rx);
		xfr_pkg::result_t beat;
		logic [15:0]      len_field;
		beat = '0;
		case (rx_phase)
			xfr_pkg::PH_BODY: begin
				run_xor ^= rx;
				body_left--;
				if (body_left == 0)
					rx_phase = xfr_pkg::PH_CHECK;
				beat.kind = xfr_pkg::KIND_BODY;
				beat.data_byte = rx;
				frame_results.insert(frame_results.size(), beat);
			end
			xfr_pkg::PH_CHECK: begin
				beat.kind = xfr_pkg::KIND_END;
				beat.received_checksum = rx;
				beat.checksum_good = (rx == run_xor) || (rx == xfr_pkg::CKSUM_ANY);
				beat.frame_last = 1'b1;
				rx_phase = xfr_pkg::PH_HEADER;
				hdr_count = '0;
				frame_results.insert(frame_results.size(), beat);
			end
			default: begin
				rx_phase = xfr_pkg::PH_HEADER;
				hdr_bytes[hdr_count] = rx;
				if (hdr_count != 3'(xfr_pkg::HDR_BYTES - 1)) begin
					hdr_count++;
				end else begin
					hdr_count = '0;
					len_field = {hdr_bytes[5], hdr_bytes[4]};
					beat.kind = xfr_pkg::KIND_ERROR;
					beat.frame_last = 1'b1;
					// The start bytes are judged before the length.
					if (hdr_bytes[0] != start_first || hdr_bytes[1] != start_second) begin
						beat.error_code = xfr_pkg::ERR_START;
					end else if (len_field < xfr_pkg::MIN_LEN) begin
						beat.error_code = xfr_pkg::ERR_LENGTH;
					end else begin
						beat.kind = xfr_pkg::KIND_HEADER;
						beat.frame_last = 1'b0;
						beat.command_code = hdr_bytes[2];
						beat.source_code = hdr_bytes[3];
						beat.device_number = {hdr_bytes[7], hdr_bytes[6]};
						body_left = len_field - xfr_pkg::MIN_LEN;
						beat.body_length = body_left;
						run_xor = hdr_bytes[6] ^ hdr_bytes[7];
						rx_phase = (body_left != 0) ? xfr_pkg::PH_BODY : xfr_pkg::PH_CHECK;
					end
					frame_results.insert(frame_results.size(), beat);
				end
			end
		endcase
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatch_count++;
		end
	endtask

	// Source side: bytes, register writes, pauses and hold requests.
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_taken || write_taken) begin
				offering = 1'b0;
				source_gap = source_tight ? 0 : pick_gap();
				if ($urandom_range(0, 63) == 0)
					source_tight = !source_tight;
			end
			if (!offering) begin
				if (source_gap > 0) begin
					source_gap--;
				end else if (pending.size() > 0) begin
					case (pending[0].kind)
						ACT_BYTE: begin
							s_tdata <= pending[0].value;
							offering = 1'b1;
							offer_write = 1'b0;
							pending.delete(0);
						end
						ACT_WRITE: begin
							cfg_index <= pending[0].index;
							cfg_data <= pending[0].value;
							offering = 1'b1;
							offer_write = 1'b1;
							pending.delete(0);
						end
						ACT_DRAIN: begin
							// Results may be done while a byte is still in the pipe.
							if (frame_results.size() != 0) begin
								quiet_cycles = 0;
							end else if (quiet_cycles >= SETTLE_CYCLES) begin
								quiet_cycles = 0;
								pending.delete(0);
							end else begin
								quiet_cycles++;
							end
						end
						default: begin
							hold_requests <= hold_requests + 1;
							pending.delete(0);
						end
					endcase
				end
			end
			s_tvalid <= offering && !offer_write;
			cfg_valid <= offering && offer_write;
		end
	end

	// Sink side: random back-pressure plus requested long holds.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken) begin
				sink_gap = sink_tight ? 0 : pick_gap();
				if ($urandom_range(0, 63) == 0)
					sink_tight = !sink_tight;
			end
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				sink_hold = $urandom_range(80, 120);
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: track writes, predict from taken bytes, check result beats.
	always @(posedge clk) begin
		byte_taken <= s_tvalid && s_tready;
		write_taken <= cfg_valid && cfg_ready;
		result_taken <= m_tvalid && m_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				writes_taken++;
				if (cfg_index == xfr_pkg::CFG_START_FIRST)
					start_first = cfg_data;
				else if (cfg_index == xfr_pkg::CFG_START_SECOND)
					start_second = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				decode_byte(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				seen_beat.kind = xfr_pkg::kind_t'(m_tuser);
				seen_beat.command_code = m_tdata[7:0];
				seen_beat.source_code = m_tdata[15:8];
				seen_beat.device_number = m_tdata[31:16];
				seen_beat.body_length = m_tdata[xfr_pkg::BODY_LEN_HI:xfr_pkg::BODY_LEN_LO];
				seen_beat.data_byte = m_tdata[55:48];
				seen_beat.received_checksum = m_tdata[63:56];
				seen_beat.checksum_good = m_tdata[64];
				seen_beat.error_code = xfr_pkg::err_t'(m_tdata[xfr_pkg::ERR_HI:xfr_pkg::ERR_LO]);
				seen_beat.frame_last = m_tlast;
				if (frame_results.size() == 0) begin
					$error("result beat of kind %0d with no result pending", m_tuser);
					mismatch_count++;
				end else begin
					want_beat = frame_results.pop_front();
					beats_checked++;
					if (want_beat.kind == xfr_pkg::KIND_END) begin
						frames_closed++;
						if (want_beat.checksum_good)
							sums_good++;
					end
					if (want_beat.kind == xfr_pkg::KIND_ERROR)
						header_errors++;
					check_field("result_kind", 16'(want_beat.kind), 16'(seen_beat.kind));
					check_field("command_code", 16'(want_beat.command_code),
						16'(seen_beat.command_code));
					check_field("source_code", 16'(want_beat.source_code),
						16'(seen_beat.source_code));
					check_field("device_number", want_beat.device_number,
						seen_beat.device_number);
					check_field("body_length", want_beat.body_length, seen_beat.body_length);
					check_field("data_byte", 16'(want_beat.data_byte),
						16'(seen_beat.data_byte));
					check_field("received_checksum", 16'(want_beat.received_checksum),
						16'(seen_beat.received_checksum));
					check_field("checksum_good", 16'(want_beat.checksum_good),
						16'(seen_beat.checksum_good));
					check_field("error_code", 16'(want_beat.error_code),
						16'(seen_beat.error_code));
					check_field("frame_last", 16'(want_beat.frame_last),
						16'(seen_beat.frame_last));
					check_field("tdata_padding", 16'd0,
						16'(m_tdata[xfr_pkg::TDATA_W-1:xfr_pkg::TDATA_FIELDS_W]));
				end
			end
			// Watchdog on beats of any channel.
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int phase_index;
		int next_phase;
		int roll;

		// Directed: empty body closed by the wildcard checksum, bad start bytes that
		// win over a short length, and a length below two.
		queue_frame(8'h00, 8'h00, 8'hFF, 8'h00, 16'd2, 16'hFFFF, SUM_ANY);
		queue_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 16'd0, 16'h0000, SUM_XOR);
		queue_frame(8'h00, 8'h00, 8'h5A, 8'hA5, 16'd1, 16'h00FF, SUM_XOR);

		// Random frames under a sequence of start byte settings.
		phase_index = 0;
		next_phase = 0;
		while (queued_bytes < BYTE_TARGET) begin
			if (queued_bytes >= next_phase) begin
				if ($urandom_range(0, 2) == 0)
					queue_write($urandom_range(0, 1) ? CFG_UNUSED_LOW : CFG_UNUSED_HIGH,
						8'($urandom));
				case (phase_index)
					0: begin
						queue_write(xfr_pkg::CFG_START_FIRST, 8'hFF);
						queue_write(xfr_pkg::CFG_START_SECOND, 8'hFF);
					end
					1: begin
						queue_write(xfr_pkg::CFG_START_FIRST, 8'h00);
						queue_write(xfr_pkg::CFG_START_SECOND, 8'hFF);
					end
					2: begin
						queue_write(xfr_pkg::CFG_START_SECOND, 8'h00);
						queue_write(xfr_pkg::CFG_START_FIRST, 8'hFF);
					end
					default: begin
						queue_write(xfr_pkg::CFG_START_FIRST, 8'($urandom));
						queue_write(xfr_pkg::CFG_START_SECOND, 8'($urandom));
					end
				endcase
				// The first phase opens with a long receiver hold over a long frame.
				if (phase_index == 0) begin
					queue_hold();
					queue_good_frame(16'd40);
				end
				phase_index++;
				next_phase += PHASE_BYTES;
			end
			roll = $urandom_range(0, 99);
			if (roll < 65) begin
				queue_good_frame(($urandom_range(0, 9) == 0) ?
					16'($urandom_range(2, 40)) : 16'($urandom_range(2, 10)));
			end else if (roll < 75) begin
				case ($urandom_range(0, 2))
					0: queue_frame(gen_first ^ 8'($urandom_range(1, 255)), gen_second,
						8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), SUM_XOR);
					1: queue_frame(gen_first, gen_second ^ 8'($urandom_range(1, 255)),
						8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), SUM_XOR);
					default: queue_frame(gen_first ^ 8'($urandom_range(1, 255)),
						gen_second ^ 8'($urandom_range(1, 255)), 8'($urandom),
						8'($urandom), 16'($urandom_range(0, 1)), 16'($urandom), SUM_XOR);
				endcase
			end else if (roll < 83) begin
				queue_frame(gen_first, gen_second, 8'($urandom), 8'($urandom),
					16'($urandom_range(0, 1)), 16'($urandom), SUM_XOR);
			end else if (roll < 90) begin
				// Line noise in whole headers, so frame alignment survives.
				queue_byte(gen_first ^ 8'($urandom_range(1, 255)));
				repeat (xfr_pkg::HDR_BYTES - 1)
					queue_byte(8'($urandom));
			end else if (roll < 95) begin
				enqueue(ACT_DRAIN, 8'd0, 8'd0);
			end else begin
				queue_hold();
				queue_good_frame(16'($urandom_range(30, 40)));
			end
		end

		// A longer frame, then a short one behind it.
		queue_good_frame(16'd20);
		queue_good_frame(16'd3);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || offering || frame_results.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d bytes and %0d register writes; checked %0d result beats.",
			bytes_taken, writes_taken, beats_checked);
		$display("Frames closed: %0d (%0d with an accepted checksum); header errors: %0d.",
			frames_closed, sums_good, header_errors);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/xfr_pkg.sv
rtl/xfr_in_stage.sv
rtl/xfr_frame_fsm.sv
rtl/xfr_out_stage.sv
rtl/xor_frame_receiver.sv
rtl/xfr_checker.sv
bench/xor_frame_receiver_test.sv
